### hdl/tpsd_pkg.sv
// Shared types and constants for the tape pulse stream decoder.
package tpsd_pkg;

  localparam int BYTE_W   = 8;
  localparam int CYC_W    = 24;
  localparam int US_W     = 25;
  localparam int PART_W   = 16;
  localparam int CLK_W    = 20;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  // Reciprocal scaling for the cycles-to-microseconds conversion.
  // The estimate is low by at most one, fixed up from the remainder.
  localparam int RECIP_SH = 25;
  localparam int K_W      = 26;
  localparam int H_W      = 25;
  localparam int P_W      = CYC_W + K_W + 1;
  localparam int REM_W    = 22;

  localparam logic [63:0] US_PER_S = 64'd1000000;

  localparam logic [CLK_W-1:0] PAL_HZ    = 20'd985248;
  localparam logic [CLK_W-1:0] PAL_HALF  = 20'd492624;
  localparam logic [CLK_W-1:0] NTSC_HZ   = 20'd1022727;
  localparam logic [CLK_W-1:0] NTSC_HALF = 20'd511363;

  localparam logic [K_W-1:0] PAL_K =
    K_W'(((64'd1 << RECIP_SH) * US_PER_S) / 64'(PAL_HZ));
  localparam logic [K_W-1:0] NTSC_K =
    K_W'(((64'd1 << RECIP_SH) * US_PER_S) / 64'(NTSC_HZ));
  localparam logic [H_W-1:0] PAL_H =
    H_W'(((64'd1 << RECIP_SH) * 64'(PAL_HALF)) / 64'(PAL_HZ));
  localparam logic [H_W-1:0] NTSC_H =
    H_W'(((64'd1 << RECIP_SH) * 64'(NTSC_HALF)) / 64'(NTSC_HZ));

  // Configuration register map (word index) and field codes.
  localparam logic REG_VIDEO_STD = 1'b0;
  localparam logic VS_NTSC       = 1'b1;

  typedef enum logic [3:0] {
    ESC_IDLE = 4'b0001,
    ESC_CNT0 = 4'b0010,
    ESC_CNT1 = 4'b0100,
    ESC_CNT2 = 4'b1000
  } esc_state_t;

  typedef struct packed {
    logic             valid;
    logic [CYC_W-1:0] cycles;
    logic             stop;
  } pulse_t;

endpackage

### hdl/tape_pulse_stream_decoder.sv
// Top level of the tape pulse stream decoder.
//
// Usage:
//   Input channel (in_valid/in_ready) takes the data bytes of a version-1
//   tape pulse file, header removed, with in_last_byte on the final byte.
//   Result channel (out_valid/out_ready) gives one request per pulse:
//   length in machine cycles, length in microseconds rounded to nearest,
//   and a stop flag. Escape openers and the first two count bytes give no
//   result; a zero count or an escape cut short by the last byte gives a
//   stop request with zero length.
//   Throughput: one byte per cycle. A result passes through three registered
//   stages after the edge that accepts its byte (parse and reciprocal
//   multiply, remainder multiply, rounding fix-up into the output register).
//   When the receiver stalls, the pipeline fills and in_ready drops only
//   once all three stages hold requests; bubbles are squeezed out.
//   video_standard (APB register 0, bit 0) picks PAL (0) or NTSC (1) clock;
//   write it only while no request is in flight.
//   Reset (rst_n low, synchronous) empties the pipeline, leaves the escape
//   state idle and selects PAL.
module tape_pulse_stream_decoder
  import tpsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_tape_byte,
  input  logic              in_last_byte,

  output logic              out_valid,
  input  logic              out_ready,
  output logic [US_W-1:0]   out_pulse_us,
  output logic [CYC_W-1:0]  out_pulse_cycles,
  output logic              out_stop,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic   video_std_r;
  logic   in_accept;
  logic   cfg_write;
  pulse_t parsed;
  pulse_t conv_req;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_VIDEO_STD);
  assign prdata    = (paddr[ADDR_W-1:2] == REG_VIDEO_STD) ?
                     {{(DATA_W-1){1'b0}}, video_std_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      video_std_r <= 1'b0;
    end else if (cfg_write) begin
      video_std_r <= pwdata[0];
    end
  end

  assign in_accept = in_valid && in_ready;

  tpsd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .tape_byte_i (in_tape_byte),
    .last_byte_i (in_last_byte),
    .accept_i    (in_accept),
    .pulse_o     (parsed)
  );

  always_comb begin
    conv_req       = parsed;
    conv_req.valid = parsed.valid && in_valid;
  end

  tpsd_us_conv u_conv (
    .clk          (clk),
    .rst_n        (rst_n),
    .video_std_i  (video_std_r),
    .req_i        (conv_req),
    .req_ready_o  (in_ready),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_us_o     (out_pulse_us),
    .out_cycles_o (out_pulse_cycles),
    .out_stop_o   (out_stop)
  );

  a_zero_pulse_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stop |-> out_pulse_cycles != '0)
    else $error("zero-length pulse without stop");

endmodule

### hdl/tpsd_parser.sv
// Byte parser: escape tracking and pulse length extraction.
module tpsd_parser
  import tpsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BYTE_W-1:0] tape_byte_i,
  input  logic              last_byte_i,
  input  logic              accept_i,
  output pulse_t            pulse_o
);

  esc_state_t        esc_r, esc_nxt;
  logic [PART_W-1:0] part_r, part_nxt;
  logic [CYC_W-1:0]  esc_count;

  assign esc_count = {tape_byte_i, part_r};

  always_comb begin
    esc_nxt        = esc_r;
    part_nxt       = part_r;
    pulse_o.valid  = 1'b0;
    pulse_o.cycles = '0;
    pulse_o.stop   = 1'b0;
    unique case (esc_r)
      ESC_IDLE: begin
        if (tape_byte_i != '0) begin
          pulse_o.valid  = 1'b1;
          pulse_o.cycles = CYC_W'({tape_byte_i, 3'b000});
          pulse_o.stop   = last_byte_i;
        end else if (last_byte_i) begin
          pulse_o.valid = 1'b1;
          pulse_o.stop  = 1'b1;
        end else begin
          esc_nxt = ESC_CNT0;
        end
      end
      ESC_CNT0: begin
        if (last_byte_i) begin
          pulse_o.valid = 1'b1;
          pulse_o.stop  = 1'b1;
          esc_nxt       = ESC_IDLE;
          part_nxt      = '0;
        end else begin
          part_nxt = PART_W'(tape_byte_i);
          esc_nxt  = ESC_CNT1;
        end
      end
      ESC_CNT1: begin
        if (last_byte_i) begin
          pulse_o.valid = 1'b1;
          pulse_o.stop  = 1'b1;
          esc_nxt       = ESC_IDLE;
          part_nxt      = '0;
        end else begin
          part_nxt = {tape_byte_i, part_r[BYTE_W-1:0]};
          esc_nxt  = ESC_CNT2;
        end
      end
      ESC_CNT2: begin
        pulse_o.valid = 1'b1;
        esc_nxt       = ESC_IDLE;
        part_nxt      = '0;
        // zero count means end of tape
        if (esc_count == '0) begin
          pulse_o.stop = 1'b1;
        end else begin
          pulse_o.cycles = esc_count;
          pulse_o.stop   = last_byte_i;
        end
      end
      default: begin
        esc_nxt  = ESC_IDLE;
        part_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r  <= ESC_IDLE;
      part_r <= '0;
    end else if (accept_i) begin
      esc_r  <= esc_nxt;
      part_r <= part_nxt;
    end
  end

  a_idle_part_clear: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r == ESC_IDLE |-> part_r == '0)
    else $error("escape partial count not cleared outside escape");

  a_cnt0_part_clear: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r == ESC_CNT0 |-> part_r == '0)
    else $error("stale partial count at first count byte");

endmodule

### hdl/tpsd_us_conv.sv
// Three-stage pipeline converting machine cycles to rounded microseconds.
module tpsd_us_conv
  import tpsd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             video_std_i,
  input  pulse_t           req_i,
  output logic             req_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [US_W-1:0]  out_us_o,
  output logic [CYC_W-1:0] out_cycles_o,
  output logic             out_stop_o
);

  logic [K_W-1:0]   k_sel;
  logic [H_W-1:0]   h_sel;
  logic [CLK_W-1:0] hz_sel;
  logic [CLK_W-1:0] half_sel;

  logic ld2, ld3, ld_out;

  // stage 2: reciprocal product and low bits of the exact numerator
  logic             s2_v_r;
  logic [P_W-1:0]   s2_p_r, s2_p_nxt;
  logic [REM_W-1:0] s2_nlo_r, s2_nlo_nxt;
  logic [CYC_W-1:0] s2_cyc_r;
  logic             s2_stop_r;

  // stage 3: quotient estimate and low bits of its remainder
  logic             s3_v_r;
  logic [US_W-1:0]  s3_q_r, s3_q_nxt;
  logic [REM_W-1:0] s3_rem_r, s3_rem_nxt;
  logic [CYC_W-1:0] s3_cyc_r;
  logic             s3_stop_r;

  logic             out_v_r;
  logic [US_W-1:0]  out_us_r, out_us_nxt;
  logic [CYC_W-1:0] out_cyc_r;
  logic             out_stop_r;

  always_comb begin
    if (video_std_i == VS_NTSC) begin
      k_sel    = NTSC_K;
      h_sel    = NTSC_H;
      hz_sel   = NTSC_HZ;
      half_sel = NTSC_HALF;
    end else begin
      k_sel    = PAL_K;
      h_sel    = PAL_H;
      hz_sel   = PAL_HZ;
      half_sel = PAL_HALF;
    end
  end

  assign ld_out      = !out_v_r || out_ready_i;
  assign ld3         = !s3_v_r || ld_out;
  assign ld2         = !s2_v_r || ld3;
  assign req_ready_o = ld2;

  assign s2_p_nxt   = P_W'(req_i.cycles) * P_W'(k_sel) + P_W'(h_sel);
  assign s2_nlo_nxt = REM_W'(req_i.cycles) * REM_W'(US_PER_S) + REM_W'(half_sel);

  // only the low remainder bits matter: the true remainder is below 2*clk
  assign s3_q_nxt   = s2_p_r[RECIP_SH +: US_W];
  assign s3_rem_nxt = s2_nlo_r - REM_W'(s3_q_nxt[REM_W-1:0]) * REM_W'(hz_sel);

  assign out_us_nxt = s3_q_r + US_W'(s3_rem_r >= REM_W'(hz_sel));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (ld2) begin
        s2_v_r <= req_i.valid;
      end
      if (ld3) begin
        s3_v_r <= s2_v_r;
      end
      if (ld_out) begin
        out_v_r <= s3_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_p_r    <= s2_p_nxt;
      s2_nlo_r  <= s2_nlo_nxt;
      s2_cyc_r  <= req_i.cycles;
      s2_stop_r <= req_i.stop;
    end
    if (ld3) begin
      s3_q_r    <= s3_q_nxt;
      s3_rem_r  <= s3_rem_nxt;
      s3_cyc_r  <= s2_cyc_r;
      s3_stop_r <= s2_stop_r;
    end
    if (ld_out) begin
      out_us_r   <= out_us_nxt;
      out_cyc_r  <= s3_cyc_r;
      out_stop_r <= s3_stop_r;
    end
  end

  assign out_valid_o  = out_v_r;
  assign out_us_o     = out_us_r;
  assign out_cycles_o = out_cyc_r;
  assign out_stop_o   = out_stop_r;

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> (REM_W + 1)'(s3_rem_r) < ((REM_W + 1)'(hz_sel) << 1))
    else $error("quotient estimate off by more than one");

  a_us_zero_iff_cyc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((out_cyc_r == '0) == (out_us_r == '0)))
    else $error("microsecond value inconsistent with cycle count");

endmodule

### test/tpsd_checker.sv
// Checker for the tape pulse stream decoder: predicts pulse requests and compares them.
`timescale 1ns / 1ps

module tpsd_checker
  import tpsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [BYTE_W-1:0] in_tape_byte,
  input  logic              in_last_byte,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [US_W-1:0]   out_pulse_us,
  input  logic [CYC_W-1:0]  out_pulse_cycles,
  input  logic              out_stop,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [31:0]       mismatches,
  output logic [31:0]       awaiting
);

  localparam logic [ADDR_W-1:0] VIDEO_STD_ADDR = {REG_VIDEO_STD, 2'b00};

  typedef struct packed {
    logic [US_W-1:0]  us;
    logic [CYC_W-1:0] cycles;
    logic             stop;
  } pulse_exp_t;

  pulse_exp_t       pending_pulses[$];
  logic             ntsc_clock;
  esc_state_t       esc_phase;
  logic [PART_W-1:0] esc_low;
  int unsigned      fail_count;

  initial begin
    fail_count = 0;
    mismatches = '0;
    awaiting   = '0;
    ntsc_clock = 1'b0;
    esc_phase  = ESC_IDLE;
    esc_low    = '0;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("tpsd_checker: %s mismatch at %0t: got %0d expected %0d", what, $realtime, got,
             want);
    fail_count++;
  endtask

  // Rounded to nearest, over the selected machine clock.
  function automatic logic [US_W-1:0] expected_us(input logic [CYC_W-1:0] cyc);
    logic [63:0] hz;
    logic [63:0] half;
    logic [63:0] q;
    hz   = ntsc_clock ? 64'(NTSC_HZ) : 64'(PAL_HZ);
    half = ntsc_clock ? 64'(NTSC_HALF) : 64'(PAL_HALF);
    q    = (64'(cyc) * 64'd1000000 + half) / hz;
    return q[US_W-1:0];
  endfunction

  task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic last);
    logic             produce;
    logic             stop;
    logic [CYC_W-1:0] cyc;
    pulse_exp_t       p;
    produce = 1'b0;
    stop    = 1'b0;
    cyc     = '0;
    case (esc_phase)
      ESC_IDLE: begin
        if (b != 0) begin
          produce = 1'b1;
          cyc     = {13'b0, b, 3'b000};
          stop    = last;
        end else if (last) begin
          produce = 1'b1;
          stop    = 1'b1;
        end else begin
          esc_phase = ESC_CNT0;
        end
      end
      ESC_CNT0, ESC_CNT1: begin
        if (last) begin
          // escape cut short by end of file
          produce   = 1'b1;
          stop      = 1'b1;
          esc_phase = ESC_IDLE;
          esc_low   = '0;
        end else if (esc_phase == ESC_CNT0) begin
          esc_low   = {8'h00, b};
          esc_phase = ESC_CNT1;
        end else begin
          esc_low[15:8] = b;
          esc_phase     = ESC_CNT2;
        end
      end
      default: begin
        cyc       = {b, esc_low};
        esc_phase = ESC_IDLE;
        esc_low   = '0;
        produce   = 1'b1;
        stop      = (cyc == 0) || last;
      end
    endcase
    if (produce) begin
      p.cycles = cyc;
      p.us     = (cyc == 0) ? '0 : expected_us(cyc);
      p.stop   = stop;
      pending_pulses.push_back(p);
    end
  endtask

  always @(posedge clk) begin
    pulse_exp_t want;
    if (!rst_n) begin
      pending_pulses.delete();
      ntsc_clock = 1'b0;
      esc_phase  = ESC_IDLE;
      esc_low    = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_pulses.size() == 0) begin
          report("unexpected request, cycles", 32'(out_pulse_cycles), 32'd0);
        end else begin
          want = pending_pulses.pop_front();
          if (out_pulse_us !== want.us)
            report("pulse_us", 32'(out_pulse_us), 32'(want.us));
          if (out_pulse_cycles !== want.cycles)
            report("pulse_cycles", 32'(out_pulse_cycles), 32'(want.cycles));
          if (out_stop !== want.stop)
            report("stop", 32'(out_stop), 32'(want.stop));
        end
      end
      if (psel && penable && pwrite && pready && paddr == VIDEO_STD_ADDR)
        ntsc_clock = (pwdata[0] == VS_NTSC);
      if (in_valid && in_ready)
        decode_byte(in_tape_byte, in_last_byte);
    end
    mismatches <= fail_count;
    awaiting   <= pending_pulses.size();
  end

endmodule

### test/tb_top.sv
// Testbench top for the tape pulse stream decoder: stimulus, register writes and verdict.
`timescale 1ns / 1ps

module tb_top
  import tpsd_pkg::*;
();

  localparam logic [ADDR_W-1:0] VIDEO_STD_ADDR = {REG_VIDEO_STD, 2'b00};
  localparam logic              VS_PAL         = ~VS_NTSC;
  localparam int                PHASE_BYTES    = 262;
  localparam int                CYCLE_LIMIT    = 300000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_tape_byte = '0;
  logic              in_last_byte = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [US_W-1:0]   out_pulse_us;
  logic [CYC_W-1:0]  out_pulse_cycles;
  logic              out_stop;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  wire  [31:0]       mismatches;
  wire  [31:0]       awaiting;

  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int          burst_left = 0;
  int          stall_left = 0;
  int          stall_mode = 0;
  logic [7:0]  rx_tick = '0;

  // {last_byte, tape_byte}: extremes, escapes, zero count, final pulses, cut-short escapes
  logic [8:0] corner_bytes [26] = '{
    9'h001, 9'h0FF, 9'h080,
    9'h000, 9'h001, 9'h002, 9'h003,
    9'h000, 9'h0FF, 9'h0FF, 9'h0FF,
    9'h000, 9'h000, 9'h000, 9'h000,
    9'h000, 9'h034, 9'h012, 9'h156,
    9'h17F,
    9'h100,
    9'h000, 9'h1AB,
    9'h000, 9'h0CD, 9'h1EF
  };

  tape_pulse_stream_decoder u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_tape_byte     (in_tape_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pulse_us     (out_pulse_us),
    .out_pulse_cycles (out_pulse_cycles),
    .out_stop         (out_stop),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  tpsd_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_tape_byte     (in_tape_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pulse_us     (out_pulse_us),
    .out_pulse_cycles (out_pulse_cycles),
    .out_stop         (out_stop),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .mismatches       (mismatches),
    .awaiting         (awaiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Receiver stalls: a new random mode is picked whenever the current one runs out.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1'b1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 100);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= rx_tick[2];
    endcase
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(5, 20) : $urandom_range(1, 4))
        @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    in_valid     <= 1'b1;
    in_tape_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    bytes_sent++;
  endtask

  // Drain all requests; escape bytes may still be in flight with no request.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_video_std(input logic sel);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= VIDEO_STD_ADDR;
    pwdata  <= {31'b0, sel};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] pick_count_byte();
    if ($urandom_range(0, 3) == 0)
      return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic pick_last();
    return ($urandom_range(0, 39) == 0);
  endfunction

  task automatic random_bytes(input int count);
    int unsigned stop_at;
    int          kind;
    logic        last;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        case ($urandom_range(0, 3))
          0: send_byte(8'h01, pick_last());
          1: send_byte(8'hFF, pick_last());
          default: send_byte(BYTE_W'($urandom_range(1, 255)), pick_last());
        endcase
      end else if (kind < 90) begin
        // escape; an early last byte cuts it short
        for (int i = 0; i < 4; i++) begin
          last = pick_last();
          send_byte(i == 0 ? 8'h00 : pick_count_byte(), last);
          if (last)
            break;
        end
      end else begin
        repeat ($urandom_range(1, 3))
          send_byte(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    logic std_sel;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_video_std(VS_PAL);
    foreach (corner_bytes[i])
      send_byte(corner_bytes[i][7:0], corner_bytes[i][8]);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 3)
        std_sel = 1'($urandom_range(0, 1));
      else
        std_sel = (ph % 2 == 0) ? VS_NTSC : VS_PAL;
      write_video_std(std_sel);
      // longest escape first, at this clock
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      random_bytes(PHASE_BYTES);
      settle();
    end

    if (mismatches == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
